// ===== hw/rtl/fat12_cluster_chain_walker_defines.svh =====
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FCCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FCCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fccw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fccw_pkg;

    // Field widths
    localparam int unsigned FAT_ADDR_W  = 13;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CLUSTER_W   = 12;
    localparam int unsigned LBA_W       = 20;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned LBA_BASE_W  = 16;
    localparam int unsigned SPC_W       = 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    // Parameter defaults
    localparam int unsigned FAT_BYTES_DEF = 8192;
    localparam int unsigned MAX_RUN_DEF   = 64;

    // Request opcodes (s_axis_tuser)
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_WALK  = 1'b1;

    // Result status (m_axis_tuser)
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

    // Config register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_START = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPC        = 1'd1;

    // Table entry codes
    localparam logic [CLUSTER_W-1:0] ENTRY_END   = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA  = 12'd2;

    localparam logic [LBA_BASE_W-1:0] DATA_START_RST = 16'd0;
    localparam logic [SPC_W-1:0]      SPC_RST        = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fat12_cluster_chain_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// FAT12 cluster chain walker.
// Input stream (s_axis_*): tuser selects the request. tuser 0 writes one
// table byte at fat_address; it gives no result.
// tuser 1 walks the chain from start_cluster and gives one result per
// visited cluster on m_axis_*: cluster number and first sector address in
// tdata, tlast on the final result, status in tuser (ok, bad cluster,
// run limit reached).
// Config port (cfg_*): index 0 data start sector, index 1 sectors per
// cluster; always ready; write only while no walk is in flight.
// Timing: the table sits in two byte banks (even and odd offsets), so
// both bytes of an entry come back in one synchronous read. Each cluster
// goes through a read step and then a decode-and-emit step. The first
// result is loaded into the output register from the emit step; the walk
// holds s_axis_tready low until its last result is loaded, stalls included.
// A stalled receiver holds the result in the output register and the walk
// waits in its emit step; nothing is dropped.
// Reset: registers return to data start 0, sectors per cluster 1; the
// table is not cleared (unwritten bytes read undefined), no clearing pass.
`include "fat12_cluster_chain_walker_defines.svh"

module fat12_cluster_chain_walker #(
    parameter int unsigned FAT_BYTES = fccw_pkg::FAT_BYTES_DEF,
    parameter int unsigned MAX_RUN   = fccw_pkg::MAX_RUN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fccw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fccw_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [12:0] fat_address, [20:13] fat_byte, [32:21] start_cluster, rest 0
    input  wire logic [fccw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] op
    input  wire logic                              s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [11:0] cluster, [31:12] lba
    output logic [fccw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tlast,
    // [1:0] status
    output logic [fccw_pkg::STATUS_W-1:0]          m_axis_tuser
);
    import fccw_pkg::*;

    localparam int unsigned BANK_DEPTH = (FAT_BYTES + 1) / 2;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
    localparam int unsigned OFF_W      = FAT_ADDR_W + 1;
    localparam int unsigned RUN_W      = $clog2(MAX_RUN + 1);
    localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RUN - 1);
    localparam logic [OFF_W-1:0] TABLE_END = OFF_W'(FAT_BYTES);

    // request fields
    logic [FAT_ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0]     in_byte;
    logic [CLUSTER_W-1:0]  in_start;
    assign in_addr  = s_axis_tdata[12:0];
    assign in_byte  = s_axis_tdata[20:13];
    assign in_start = s_axis_tdata[32:21];

    // control state
    state_t               state_reg, state_next;
    logic [CLUSTER_W-1:0] cur_reg, cur_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic                 bad_reg, bad_next;
    logic [LBA_W-1:0]     prod_reg, prod_next;
    logic [LBA_BASE_W-1:0] dsl_reg;
    logic [SPC_W-1:0]     spc_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [CLUSTER_W-1:0] m_cluster_reg;
    logic [LBA_W-1:0]     m_lba_reg;
    logic                 m_last_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic                 out_load;
    logic [LBA_W-1:0]     out_lba;
    logic                 out_last;
    logic [STATUS_W-1:0]  out_status;

    // table banks
    logic [BYTE_W-1:0] bank_even [BANK_DEPTH];
    logic [BYTE_W-1:0] bank_odd  [BANK_DEPTH];
    logic [BYTE_W-1:0] rd_even_reg, rd_odd_reg;
    logic              off_odd_reg, lo_oob_reg, hi_oob_reg;

    logic                 in_acc, walk_acc, wr_en, rd_en;
    logic [OFF_W-1:0]     off, off_p1;
    logic [BYTE_W-1:0]    lo_byte, hi_byte;
    logic [CLUSTER_W-1:0] nxt, cur_m2;
    logic                 out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign walk_acc      = in_acc && (s_axis_tuser == OP_WALK);
    assign wr_en  = in_acc && (s_axis_tuser == OP_WRITE)
                    && ({1'b0, in_addr} < TABLE_END);
    assign rd_en  = (state_reg == S_READ);

    // entry offset = cluster * 3 / 2
    assign off    = OFF_W'(cur_reg) + OFF_W'(cur_reg[CLUSTER_W-1:1]);
    assign off_p1 = off + OFF_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsl_reg <= DATA_START_RST;
            spc_reg <= SPC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DATA_START: dsl_reg <= cfg_data;
                REG_SPC:        spc_reg <= cfg_data[SPC_W-1:0];
                default:        ;
            endcase
        end
    end

    // Even bank holds offsets 2i, odd bank 2i+1. The even byte of the pair is
    // off+1 at off_p1>>1 when off is odd, and off at off>>1 (same) when off
    // is even, so the even bank is always indexed by off_p1.
    always_ff @(posedge clk)
    begin
        if (wr_en && !in_addr[0])
        begin
            bank_even[in_addr[BANK_AW:1]] <= in_byte;
        end
        if (wr_en && in_addr[0])
        begin
            bank_odd[in_addr[BANK_AW:1]] <= in_byte;
        end
        if (rd_en)
        begin
            rd_even_reg <= bank_even[off_p1[BANK_AW:1]];
            rd_odd_reg  <= bank_odd[off[BANK_AW:1]];
            off_odd_reg <= off[0];
            lo_oob_reg  <= (off >= TABLE_END);
            hi_oob_reg  <= (off_p1 >= TABLE_END);
        end
    end

    // entry decode
    always_comb
    begin
        lo_byte = off_odd_reg ? rd_odd_reg : rd_even_reg;
        hi_byte = off_odd_reg ? rd_even_reg : rd_odd_reg;
        if (lo_oob_reg)
        begin
            lo_byte = '0;
        end
        if (hi_oob_reg)
        begin
            hi_byte = '0;
        end
        nxt = cur_reg[0] ? {hi_byte, lo_byte[7:4]} : {hi_byte[3:0], lo_byte};
    end

    assign cur_m2   = cur_reg - FIRST_DATA;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        run_next   = run_reg;
        bad_next   = bad_reg;
        prod_next  = prod_reg;
        out_load   = 1'b0;
        out_lba    = LBA_W'(dsl_reg) + prod_reg;
        out_last   = 1'b0;
        out_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (walk_acc)
                begin
                    cur_next   = in_start;
                    run_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // table read in flight; offset product for the sector address
                prod_next  = {8'b0, cur_m2} * {12'b0, spc_reg};
                bad_next   = (cur_reg < FIRST_DATA);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (bad_reg)
                    begin
                        out_lba    = '0;
                        out_last   = 1'b1;
                        out_status = ST_BAD;
                        state_next = S_IDLE;
                    end
                    else if (nxt >= ENTRY_END)
                    begin
                        out_last   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (run_reg == RUN_LAST)
                    begin
                        out_last   = 1'b1;
                        out_status = ST_TRUNC;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = nxt;
                        run_next   = run_reg + RUN_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cur_reg     <= '0;
            run_reg     <= '0;
            bad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            run_reg     <= run_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (out_load)
        begin
            m_cluster_reg <= cur_reg;
            m_lba_reg     <= out_lba;
            m_last_reg    <= out_last;
            m_status_reg  <= out_status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_lba_reg, m_cluster_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_status_reg;

    `FCCW_ASSERT_NEXT(a_walk_reads, walk_acc, state_reg == S_READ, "walk did not start a read")
    `FCCW_ASSERT_NEXT(a_last_idle, out_load && out_last, state_reg == S_IDLE, "walk did not end")
    `FCCW_ASSERT_NOW(a_trunc_limit, out_status == ST_TRUNC, run_reg == RUN_LAST, "early limit")
    `FCCW_ASSERT_NEXT(a_read_emit, state_reg == S_READ, state_reg == S_EMIT, "read without emit")

endmodule

`default_nettype wire
